### src/nps_pkg.sv
// Shared constants, codes and control structs for the nearest point search unit.
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

    localparam int CAPACITY    = 1024;
    localparam int INDEX_W     = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int COORD_W     = 16;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int OUT_INDEX_W = 10;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int S_DATA_W    = 2 * COORD_W;
    localparam int M_DATA_W    = ((OUT_INDEX_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // input item accepted this cycle
        logic scan;      // issue one table read this cycle
        logic finish;    // scan drained, latch the best index as the result
        logic load_out;  // move the pending result into the output register
    } nps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // table holds no points
        logic scan_last;   // current read address is the last stored entry
        logic pipe_empty;  // no read is in flight in the distance pipeline
    } nps_status_t;

endpackage : nps_pkg

`default_nettype wire

### src/nearest_point_search_unit.sv
// Top level of the brute-force 2-D nearest point search unit.
//
//  Channel  Ports                       Contents (lowest bit first)
//  -------  --------------------------  ------------------------------------------
//  input    s_tvalid s_tready           s_tuser: command [1:0]
//           s_tdata s_tuser             s_tdata: pos_x [15:0], pos_y [31:16]
//  result   m_tvalid m_tready           m_tuser: status [1:0]
//           m_tdata m_tuser             m_tdata: nearest_index [9:0], zeros [15:10]
//
// An insert, clear or unused command, or a query on an empty table, goes from
// acceptance through the pending result register into the output register. A
// query on a non-empty table walks the table through the single read port of the
// point memory, one entry per cycle. Reset is synchronous and active low; it
// empties the table (no clearing pass, the point memory itself is not reset) and
// drops any pending result. The result sits in an output register, so the next
// item is accepted while a result still waits for m_tready; a stalled result
// holds the block in its reply step only for an item whose own result is ready.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_search_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [nps_pkg::S_DATA_W-1:0]    s_tdata,  // pos_x, pos_y
    input  wire logic [nps_pkg::CMD_W-1:0]       s_tuser,  // command
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [nps_pkg::M_DATA_W-1:0]         m_tdata,  // nearest_index, zero pad
    output logic [nps_pkg::STATUS_W-1:0]         m_tuser   // status
);
    import nps_pkg::*;

    // The controller sequences each item; the datapath owns the table and math.
    nps_cmd_t    ctrl_cmd;
    nps_status_t dp_status;

    nps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (ctrl_cmd),
        .status   (dp_status)
    );

    // Distances are exact squared Euclidean values; a strict less-than keeps
    // the lowest index when two points are equally near.
    nps_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (ctrl_cmd),
        .status     (dp_status),
        .in_cmd     (s_tuser),
        .in_data    (s_tdata),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule : nearest_point_search_unit

`default_nettype wire

### src/nps_datapath.sv
// Point table, distance pipeline, best-candidate tracking and result registers.
`timescale 1ns / 1ps
`default_nettype none

module nps_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire nps_pkg::nps_cmd_t                cmd,
    output nps_pkg::nps_status_t                  status,
    input  wire logic [nps_pkg::CMD_W-1:0]        in_cmd,
    input  wire logic [nps_pkg::S_DATA_W-1:0]     in_data,
    output logic [nps_pkg::M_DATA_W-1:0]          out_data,
    output logic [nps_pkg::STATUS_W-1:0]          out_status
);
    import nps_pkg::*;

    logic [S_DATA_W-1:0]    mem [CAPACITY];

    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [INDEX_W-1:0]     rd_addr_reg;
    logic [COORD_W-1:0]     qx_reg, qy_reg;

    logic                   v1_reg, v2_reg, v3_reg;
    logic [INDEX_W-1:0]     idx1_reg, idx2_reg, idx3_reg;
    logic [S_DATA_W-1:0]    rd_data_reg;
    logic [COORD_W-1:0]     dx_reg, dy_reg;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;

    logic [DIST_W-1:0]      best_d_reg;
    logic [INDEX_W-1:0]     best_idx_reg;

    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [OUT_INDEX_W-1:0] res_index_reg, res_index_next;
    logic [OUT_INDEX_W-1:0] out_index_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic [COORD_W-1:0]     in_x, in_y, px, py;
    logic                   full;
    logic                   do_insert;
    logic [DIST_W-1:0]      cand_d;
    logic                   better;

    assign in_x      = in_data[COORD_W-1:0];
    assign in_y      = in_data[S_DATA_W-1:COORD_W];
    assign px        = rd_data_reg[COORD_W-1:0];
    assign py        = rd_data_reg[S_DATA_W-1:COORD_W];
    assign full      = (count_reg == COUNT_W'(CAPACITY));
    assign do_insert = cmd.take && (in_cmd == CMD_INSERT) && !full;

    assign cand_d = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign better = (idx3_reg == '0) || (cand_d < best_d_reg);

    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = ({1'b0, rd_addr_reg} == COUNT_W'(count_reg - 1'b1));
    assign status.pipe_empty = !(v1_reg || v2_reg || v3_reg);

    // Entry count and the pending result of the current item.
    always_comb begin
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        if (cmd.take) begin
            res_status_next = ST_DONE;
            res_index_next  = '0;
            unique case (in_cmd)
                CMD_INSERT: begin
                    if (full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        res_index_next = OUT_INDEX_W'(count_reg);
                        count_next     = COUNT_W'(count_reg + 1'b1);
                    end
                end
                CMD_QUERY: begin
                    if (count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                    end
                end
                CMD_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end else if (cmd.finish) begin
            res_status_next = ST_DONE;
            res_index_next  = OUT_INDEX_W'(best_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_insert) begin
            mem[count_reg[INDEX_W-1:0]] <= in_data;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_addr_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.take) begin
                rd_addr_reg <= '0;
            end else if (cmd.scan) begin
                rd_addr_reg <= INDEX_W'(rd_addr_reg + 1'b1);
            end
            v1_reg <= cmd.scan;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Distance pipeline: read data, absolute differences, squares, sum and compare.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            qx_reg <= in_x;
            qy_reg <= in_y;
        end
        idx1_reg <= rd_addr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dx_reg   <= (px >= qx_reg) ? COORD_W'(px - qx_reg) : COORD_W'(qx_reg - px);
        dy_reg   <= (py >= qy_reg) ? COORD_W'(py - qy_reg) : COORD_W'(qy_reg - py);
        sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        if (v3_reg && better) begin
            best_d_reg   <= cand_d;
            best_idx_reg <= idx3_reg;
        end
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
        end
    end

    assign out_data   = M_DATA_W'(out_index_reg);
    assign out_status = out_status_reg;

endmodule : nps_datapath

`default_nettype wire

### src/nps_ctrl.sv
// Controller state machine: input handshake, scan sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none

module nps_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [nps_pkg::CMD_W-1:0]  in_cmd,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output nps_pkg::nps_cmd_t               cmd,
    input  wire nps_pkg::nps_status_t       status
);
    import nps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_REPLY = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.take     = 1'b0;
        cmd.scan     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if ((in_cmd == CMD_QUERY) && !status.count_zero) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (status.pipe_empty) begin
                    cmd.finish = 1'b1;
                    state_next = S_REPLY;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule : nps_ctrl

`default_nettype wire

### src/nps_checker.sv
// Port-level assertions for the nearest point search unit and their bind.
`timescale 1ns / 1ps
`default_nettype none

module nps_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [nps_pkg::M_DATA_W-1:0]    m_tdata,
    input wire logic [nps_pkg::STATUS_W-1:0]    m_tuser
);
    import nps_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset drops any pending result.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Two items are never accepted back to back.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // The unused status code never appears.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != ST_BAD)
        else $error("undefined status code");

    // A full or empty report carries index zero.
    a_refused_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DONE |-> m_tdata == '0)
        else $error("nonzero index on refused item");

endmodule : nps_checker

bind nearest_point_search_unit nps_checker u_nps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
